@@ design/bfa_pkg.sv @@
// ---------------------------------------------------------------------------
// Bitmap frame allocator package
// Shared constants, codes and types for the allocator and its channels.
// ---------------------------------------------------------------------------
package bfa_pkg;

    // Default sizing of the bitmap and the frame
    localparam int BITMAP_WORDS_DEF = 4096;
    localparam int FRAME_SHIFT_DEF  = 12;

    // Fixed field widths
    localparam int WORD_BITS  = 32;
    localparam int ADDR_W     = 32;
    localparam int FNUM_W     = 17;
    localparam int CNT_W      = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Request codes
    typedef enum logic [1:0] {
        ACT_ALLOC     = 2'd0,
        ACT_FREE_ADDR = 2'd1,
        ACT_MARK_USED = 2'd2,
        ACT_MARK_FREE = 2'd3
    } t_action;

    // Result codes
    typedef enum logic [1:0] {
        STS_OK           = 2'd0,
        STS_NO_FREE      = 2'd1,
        STS_OUT_OF_RANGE = 2'd2
    } t_status;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_ADDRESS = 2'd0,
        REG_FRAME_COUNT  = 2'd1
    } t_cfg_reg;

endpackage

@@ design/bfa_if.sv @@
// ---------------------------------------------------------------------------
// Bitmap frame allocator channels
// Request, result and configuration channels, valid/ready handshake.
// ---------------------------------------------------------------------------

// Request channel
interface bfa_req_if
    import bfa_pkg::*;
();
    logic                valid;
    logic                ready;
    t_action             action;
    logic [ADDR_W-1:0]   address;
    logic [FNUM_W-1:0]   frame_number;

    modport source (output valid, action, address, frame_number, input ready);
    modport sink   (input valid, action, address, frame_number, output ready);
endinterface

// Result channel
interface bfa_rsp_if
    import bfa_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [FNUM_W-1:0]   frame_index;
    logic [ADDR_W-1:0]   frame_address;
    t_status             status;
    logic [CNT_W-1:0]    frames_in_use;

    modport source (output valid, frame_index, frame_address, status, frames_in_use,
                    input ready);
    modport sink   (input valid, frame_index, frame_address, status, frames_in_use,
                    output ready);
endinterface

// Configuration write channel
interface bfa_cfg_if
    import bfa_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ design/bitmap_frame_allocator.sv @@
// ---------------------------------------------------------------------------
// Bitmap frame allocator
// First-fit physical frame allocator over a used-bit bitmap held in RAM.
// ---------------------------------------------------------------------------
//  Channel  Dir  Beat contents
//  i_req    in   action, address, frame_number
//  o_rsp    out  frame_index, frame_address, status, frames_in_use
//  i_cfg    in   index, data (base_address, frame_count)
//
//  After reset a clearing pass writes every bitmap word to zero, one word a
//  cycle; i_req is not ready meanwhile, i_cfg always is.
//  Allocate scans the bitmap one word a cycle through the RAM read port
//  and skips the scan on an empty region; free and mark read, modify and
//  write back the word, and skip the modify when the frame is out of
//  range. One request is in flight at a time; a result waits in the output
//  register, and a new request is taken while it waits.
// ---------------------------------------------------------------------------
module bitmap_frame_allocator
    import bfa_pkg::*;
#(
    parameter int BITMAP_WORDS = BITMAP_WORDS_DEF,
    parameter int FRAME_SHIFT  = FRAME_SHIFT_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bfa_req_if.sink   i_req,
    bfa_rsp_if.source o_rsp,
    bfa_cfg_if.sink   i_cfg
);

    localparam int WAW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam logic [31:0]    CAP       = 32'(BITMAP_WORDS * WORD_BITS);
    localparam logic [WAW-1:0] LAST_WORD = WAW'(BITMAP_WORDS - 1);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_MODIFY,
        S_SCAN,
        S_RESP
    } t_state;

    t_state              r_state;
    logic [WAW-1:0]      r_clr_addr;
    logic [ADDR_W-1:0]   r_base;
    logic [CNT_W-1:0]    r_fcount;
    logic [CNT_W-1:0]    r_count;
    t_action             r_action;
    logic [ADDR_W-1:0]   r_addr;
    logic [FNUM_W-1:0]   r_fnum;
    logic [CNT_W-1:0]    r_frame;
    logic [WAW-1:0]      r_word;
    t_status             r_status;
    logic [WAW-1:0]      r_scan_addr;
    logic [WAW-1:0]      r_chk_addr;
    logic                r_pend;
    logic                r_out_valid;
    logic [FNUM_W-1:0]   r_out_index;
    logic [ADDR_W-1:0]   r_out_addr;
    t_status             r_out_status;
    logic [CNT_W-1:0]    r_out_count;

    logic [CNT_W-1:0]      w_limit;
    logic [31:0]           w_last_word;
    logic [31:0]           w_req_frame;
    logic                  w_req_oor;
    logic [WORD_BITS-1:0]  w_rdata;
    logic [WORD_BITS-1:0]  w_free;
    logic [4:0]            w_first;
    logic                  w_any;
    logic [31:0]           w_found_frame;
    logic                  w_found_ok;
    logic                  w_bit;
    logic                  w_set;
    logic [WORD_BITS-1:0]  w_mask;
    logic                  w_we;
    logic [WAW-1:0]        w_waddr;
    logic [WORD_BITS-1:0]  w_wdata;
    logic [WAW-1:0]        w_raddr;
    logic                  w_out_load;

    // Managed range: frame_count clamped to the bitmap capacity
    assign w_limit     = ({14'd0, r_fcount} < CAP) ? r_fcount : CAP[CNT_W-1:0];
    assign w_last_word = (32'(w_limit) - 32'd1) >> 5;

    // Frame named by a free or mark request
    assign w_req_frame = (r_action == ACT_FREE_ADDR) ? ((r_addr - r_base) >> FRAME_SHIFT)
                                                     : 32'(r_fnum);
    assign w_req_oor   = (w_req_frame >= 32'(w_limit));

    // Lowest clear bit of the word under check
    assign w_free = ~w_rdata;
    always_comb begin
        w_first = 5'd0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (w_free[b]) begin
                w_first = 5'(b);
            end
        end
    end
    assign w_any         = |w_free;
    assign w_found_frame = 32'({r_chk_addr, w_first});
    assign w_found_ok    = w_any && (w_found_frame < 32'(w_limit));

    // Bit of the frame being marked
    assign w_bit  = w_rdata[r_frame[4:0]];
    assign w_set  = (r_action == ACT_MARK_USED);
    assign w_mask = WORD_BITS'(1) << r_frame[4:0];

    // Drive the bitmap write port
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_word;
        w_wdata = w_rdata;
        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_clr_addr;
                w_wdata = '0;
            end
            S_MODIFY: begin
                w_we    = (w_set != w_bit);
                w_waddr = r_word;
                w_wdata = w_set ? (w_rdata | w_mask) : (w_rdata & ~w_mask);
            end
            S_SCAN: begin
                w_we    = r_pend && w_found_ok;
                w_waddr = r_chk_addr;
                w_wdata = w_rdata | (WORD_BITS'(1) << w_first);
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // Pick the bitmap read address
    assign w_raddr = (r_state == S_DECODE) ? w_req_frame[WAW+4:5] : r_scan_addr;

    bfa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (BITMAP_WORDS)
    ) u_bfa_bitmap (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_out_load = (r_state == S_RESP) && (!r_out_valid || o_rsp.ready);

    // Sequencer, counters and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_base      <= '0;
            r_fcount    <= '0;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // Configuration writes
            if (i_cfg.valid) begin
                case (t_cfg_reg'(i_cfg.index))
                    REG_BASE_ADDRESS: r_base   <= i_cfg.data;
                    REG_FRAME_COUNT:  r_fcount <= i_cfg.data[CNT_W-1:0];
                    default: ;
                endcase
            end

            // Drop the result once taken, unless a new one loads
            if (o_rsp.ready && !w_out_load) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + WAW'(1);
                    if (r_clr_addr == LAST_WORD) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_action    <= i_req.action;
                        r_addr      <= i_req.address;
                        r_fnum      <= i_req.frame_number;
                        r_scan_addr <= '0;
                        r_pend      <= 1'b0;
                        if (i_req.action != ACT_ALLOC) begin
                            r_state <= S_DECODE;
                        end else if (w_limit == '0) begin
                            r_status <= STS_NO_FREE;
                            r_state  <= S_RESP;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_DECODE: begin
                    r_frame <= w_req_frame[CNT_W-1:0];
                    r_word  <= w_req_frame[WAW+4:5];
                    if (w_req_oor) begin
                        r_status <= STS_OUT_OF_RANGE;
                        r_state  <= S_RESP;
                    end else begin
                        r_state <= S_MODIFY;
                    end
                end
                S_MODIFY: begin
                    if (w_set && !w_bit) begin
                        r_count <= r_count + CNT_W'(1);
                    end else if (!w_set && w_bit) begin
                        r_count <= r_count - CNT_W'(1);
                    end
                    r_status <= STS_OK;
                    r_state  <= S_RESP;
                end
                S_SCAN: begin
                    // Issue one word read a cycle, check the word read last cycle
                    r_pend     <= 1'b1;
                    r_chk_addr <= r_scan_addr;
                    if (r_scan_addr != LAST_WORD) begin
                        r_scan_addr <= r_scan_addr + WAW'(1);
                    end
                    if (r_pend) begin
                        if (w_found_ok) begin
                            r_frame  <= w_found_frame[CNT_W-1:0];
                            r_count  <= r_count + CNT_W'(1);
                            r_status <= STS_OK;
                            r_pend   <= 1'b0;
                            r_state  <= S_RESP;
                        end else if (w_any || (32'(r_chk_addr) >= w_last_word)) begin
                            r_status <= STS_NO_FREE;
                            r_pend   <= 1'b0;
                            r_state  <= S_RESP;
                        end
                    end
                end
                S_RESP: begin
                    if (w_out_load) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_status;
                        r_out_count  <= r_count;
                        if (r_status == STS_OK) begin
                            r_out_index <= r_frame[FNUM_W-1:0];
                            r_out_addr  <= r_base + (32'(r_frame) << FRAME_SHIFT);
                        end else begin
                            r_out_index <= '0;
                            r_out_addr  <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready         = (r_state == S_IDLE);
    assign i_cfg.ready         = 1'b1;
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.frame_index   = r_out_index;
    assign o_rsp.frame_address = r_out_addr;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.frames_in_use = r_out_count;

endmodule

@@ design/bfa_ram.sv @@
// ---------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module bfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/bfa_checker.sv @@
// ---------------------------------------------------------------------------
// Bitmap frame allocator checker
// Port-level assertions, bound to the allocator top level.
// ---------------------------------------------------------------------------
module bfa_checker
    import bfa_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_req_valid,
    input logic              i_req_ready,
    input logic              i_rsp_valid,
    input logic              i_rsp_ready,
    input logic [FNUM_W-1:0] i_rsp_frame_index,
    input logic [ADDR_W-1:0] i_rsp_frame_address,
    input t_status           i_rsp_status,
    input logic [CNT_W-1:0]  i_rsp_frames_in_use
);

    // One request at a time: busy right after a request beat
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request taken while previous request in progress");

    // A failed request reports no frame
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && (i_rsp_status != STS_OK)) |->
            ((i_rsp_frame_index == '0) && (i_rsp_frame_address == '0)))
        else $error("failed result carries a frame");

    // Hold a stalled result beat
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_rsp_frame_index) && $stable(i_rsp_frame_address)
             && $stable(i_rsp_status) && $stable(i_rsp_frames_in_use)))
        else $error("stalled result changed");

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .i_req_valid         (i_req.valid),
    .i_req_ready         (i_req.ready),
    .i_rsp_valid         (o_rsp.valid),
    .i_rsp_ready         (o_rsp.ready),
    .i_rsp_frame_index   (o_rsp.frame_index),
    .i_rsp_frame_address (o_rsp.frame_address),
    .i_rsp_status        (o_rsp.status),
    .i_rsp_frames_in_use (o_rsp.frames_in_use)
);

@@ tb/bitmap_frame_allocator_checker.sv @@
// ---------------------------------------------------------------------------
// Bitmap frame allocator checker
// Watches the request, result and configuration channels, keeps a private
// model of the used-frame bitmap and compares every result beat with the
// oldest outstanding prediction.
// ---------------------------------------------------------------------------
module bitmap_frame_allocator_checker
    import bfa_pkg::*;
#(
    parameter int BITMAP_WORDS = BITMAP_WORDS_DEF,
    parameter int FRAME_SHIFT  = FRAME_SHIFT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bfa_req_if        mon_req,
    bfa_rsp_if        mon_rsp,
    bfa_cfg_if        mon_cfg,
    output int        o_mismatches,
    output int        o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CAPACITY = BITMAP_WORDS * WORD_BITS;

    typedef struct {
        logic [FNUM_W-1:0] frame_index;
        logic [ADDR_W-1:0] frame_address;
        t_status           status;
        logic [CNT_W-1:0]  frames_in_use;
    } t_alloc_result;

    logic [WORD_BITS-1:0] used_map [BITMAP_WORDS];
    logic [CNT_W-1:0]     used_total;
    logic [ADDR_W-1:0]    base_reg;
    logic [CNT_W-1:0]     count_reg;
    t_alloc_result        awaited_results [$];
    int                   mismatch_count;

    // Set or clear one frame; the count moves only when the bit flips
    function automatic void flip_frame(input int unsigned f, input bit make_used);
        logic was;
        was = used_map[f / WORD_BITS][f % WORD_BITS];
        if (make_used && !was) begin
            used_map[f / WORD_BITS][f % WORD_BITS] = 1'b1;
            used_total = used_total + 1'b1;
        end else if (!make_used && was) begin
            used_map[f / WORD_BITS][f % WORD_BITS] = 1'b0;
            used_total = used_total - 1'b1;
        end
    endfunction

    // Apply one request to the bitmap and work out the result beat
    function automatic t_alloc_result serve_request(input t_action act,
                                                    input logic [ADDR_W-1:0] addr,
                                                    input logic [FNUM_W-1:0] fnum);
        int unsigned   lim;
        int unsigned   nwords;
        int unsigned   frame;
        logic [31:0]   target;
        bit            found;
        t_alloc_result r;
        lim    = (count_reg < CAPACITY) ? count_reg : CAPACITY;
        frame  = 0;
        found  = 1'b0;
        r.status = STS_OK;
        if (act == ACT_ALLOC) begin
            // First fit: lowest clear bit below the limit, partial word included
            nwords = (lim + WORD_BITS - 1) / WORD_BITS;
            for (int unsigned w = 0; w < nwords && !found; w++) begin
                if (!(&used_map[w])) begin
                    for (int unsigned b = 0; b < WORD_BITS && !found; b++) begin
                        if (w * WORD_BITS + b < lim && !used_map[w][b]) begin
                            found = 1'b1;
                            frame = w * WORD_BITS + b;
                        end
                    end
                end
            end
            if (found)
                flip_frame(frame, 1'b1);
            else
                r.status = STS_NO_FREE;
        end else begin
            if (act == ACT_FREE_ADDR)
                target = (addr - base_reg) >> FRAME_SHIFT;
            else
                target = 32'(fnum);
            if (target >= lim) begin
                r.status = STS_OUT_OF_RANGE;
            end else begin
                frame = target;
                flip_frame(frame, act == ACT_MARK_USED);
            end
        end
        if (r.status != STS_OK) begin
            r.frame_index   = '0;
            r.frame_address = '0;
        end else begin
            r.frame_index   = frame[FNUM_W-1:0];
            r.frame_address = base_reg + (32'(frame) << FRAME_SHIFT);
        end
        r.frames_in_use = used_total;
        return r;
    endfunction

    // Track every handshake at the rising edge
    always @(posedge i_clk) begin
        t_alloc_result want;
        if (!i_rst_n) begin
            for (int w = 0; w < BITMAP_WORDS; w++)
                used_map[w] = '0;
            used_total = '0;
            base_reg   = '0;
            count_reg  = '0;
            awaited_results.delete();
        end else begin
            // Compare a result beat with the oldest prediction
            if (mon_rsp.valid === 1'b1 && mon_rsp.ready === 1'b1) begin
                if (awaited_results.size() == 0) begin
                    $error("result beat with no request outstanding");
                    mismatch_count++;
                end else begin
                    want = awaited_results.pop_front();
                    if (mon_rsp.frame_index !== want.frame_index) begin
                        $error("frame_index: expected %0d, actual %0d",
                               want.frame_index, mon_rsp.frame_index);
                        mismatch_count++;
                    end
                    if (mon_rsp.frame_address !== want.frame_address) begin
                        $error("frame_address: expected %08h, actual %08h",
                               want.frame_address, mon_rsp.frame_address);
                        mismatch_count++;
                    end
                    if (mon_rsp.status !== want.status) begin
                        $error("status: expected %0d, actual %0d",
                               want.status, mon_rsp.status);
                        mismatch_count++;
                    end
                    if (mon_rsp.frames_in_use !== want.frames_in_use) begin
                        $error("frames_in_use: expected %0d, actual %0d",
                               want.frames_in_use, mon_rsp.frames_in_use);
                        mismatch_count++;
                    end
                end
            end

            // Latch register writes; unknown indexes are dropped
            if (mon_cfg.valid === 1'b1 && mon_cfg.ready === 1'b1) begin
                case (mon_cfg.index)
                    REG_BASE_ADDRESS: base_reg  = mon_cfg.data;
                    REG_FRAME_COUNT:  count_reg = mon_cfg.data[CNT_W-1:0];
                    default: ;
                endcase
            end

            // Predict the result of an accepted request beat
            if (mon_req.valid === 1'b1 && mon_req.ready === 1'b1)
                awaited_results.push_back(serve_request(mon_req.action,
                                                        mon_req.address,
                                                        mon_req.frame_number));
        end
        o_outstanding = awaited_results.size();
        o_mismatches  = mismatch_count;
    end

endmodule

@@ tb/bitmap_frame_allocator_tb.sv @@
// ---------------------------------------------------------------------------
// Bitmap frame allocator testbench
// Drives directed and random allocate, free and mark requests across several
// region settings, with random idle and stall bursts and one long result
// hold-off; the checker beside the block predicts and compares each beat.
// ---------------------------------------------------------------------------
module bitmap_frame_allocator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bfa_pkg::*;

    localparam int unsigned CAPACITY    = BITMAP_WORDS_DEF * WORD_BITS;
    localparam int unsigned MAX_FRAME   = (1 << FNUM_W) - 1;
    localparam int          LONG_HOLD   = 200;
    localparam int          PHASES      = 14;
    localparam int          PHASE_ITEMS = 100;

    // Register indexes the block does not decode
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    logic i_clk;
    logic i_rst_n;

    bfa_req_if req_bus ();
    bfa_rsp_if rsp_bus ();
    bfa_cfg_if cfg_bus ();

    int          mismatches;
    int          results_outstanding;
    bit          quiet_mode;
    bit          hold_request;
    int          send_idle_pct;
    int          stall_pct;
    int unsigned cur_base;
    int unsigned cur_limit;

    bitmap_frame_allocator #(
        .BITMAP_WORDS(BITMAP_WORDS_DEF),
        .FRAME_SHIFT (FRAME_SHIFT_DEF)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_bus),
        .o_rsp  (rsp_bus),
        .i_cfg  (cfg_bus)
    );

    bitmap_frame_allocator_checker #(
        .BITMAP_WORDS(BITMAP_WORDS_DEF),
        .FRAME_SHIFT (FRAME_SHIFT_DEF)
    ) u_monitor (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .mon_req      (req_bus),
        .mon_rsp      (rsp_bus),
        .mon_cfg      (cfg_bus),
        .o_mismatches (mismatches),
        .o_outstanding(results_outstanding)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Guard against a hang
    initial begin
        #5_000_000;
        $display("bitmap_frame_allocator_tb failed");
        $finish;
    end

    // Result ready: short random stalls, one long hold-off on request
    initial begin
        int stall_left;
        bit hold_taken;
        stall_left    = 0;
        hold_taken    = 1'b0;
        rsp_bus.ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                rsp_bus.ready = 1'b0;
                stall_left--;
            end else if (hold_request && !hold_taken) begin
                hold_taken    = 1'b1;
                rsp_bus.ready = 1'b0;
                stall_left    = LONG_HOLD - 1;
            end else if (!quiet_mode && $urandom_range(1, 100) <= stall_pct) begin
                rsp_bus.ready = 1'b0;
                stall_left    = $urandom_range(0, 2);
            end else begin
                rsp_bus.ready = 1'b1;
            end
        end
    end

    // Offer one request beat and hold it until accepted
    task automatic issue(input t_action act, input logic [ADDR_W-1:0] addr,
                         input logic [FNUM_W-1:0] fnum);
        @(negedge i_clk);
        if (!quiet_mode && $urandom_range(1, 100) <= send_idle_pct) begin
            req_bus.valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        req_bus.valid        = 1'b1;
        req_bus.action       = act;
        req_bus.address      = addr;
        req_bus.frame_number = fnum;
        do @(posedge i_clk); while (req_bus.ready !== 1'b1);
    endtask

    // Drop the request channel and wait for every result to come back
    task automatic settle();
        @(negedge i_clk);
        req_bus.valid = 1'b0;
        wait (results_outstanding == 0);
    endtask

    // Write one configuration register
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data  = data;
        do @(posedge i_clk); while (cfg_bus.ready !== 1'b1);
        @(negedge i_clk);
        cfg_bus.valid = 1'b0;
        if (idx == REG_BASE_ADDRESS)
            cur_base = data;
        else if (idx == REG_FRAME_COUNT)
            cur_limit = (data[CNT_W-1:0] < CAPACITY) ? data[CNT_W-1:0] : CAPACITY;
    endtask

    // Pick a frame mostly inside the managed range, sometimes at or past it
    function automatic int unsigned pick_frame(input int unsigned lim);
        int unsigned f;
        case ($urandom_range(0, 9))
            0:       f = $urandom_range(0, MAX_FRAME);
            1:       f = lim;
            2:       f = (lim == 0) ? 0 : lim - 1;
            default: f = $urandom_range(0, (lim > 256) ? 255 : lim + 1);
        endcase
        return (f > MAX_FRAME) ? MAX_FRAME : f;
    endfunction

    // Pick a frame count for a phase, biased toward small regions
    function automatic int unsigned pick_count();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return $urandom_range(1, 8);
            2, 3:    return $urandom_range(9, 40);
            4:       return ($urandom_range(0, 1) == 1) ? 32 : 64;
            5:       return $urandom_range(41, 200);
            6:       return $urandom_range(200, 1500);
            7:       return CAPACITY;
            8:       return $urandom_range(CAPACITY + 1, (1 << CNT_W) - 1);
            default: return $urandom_range(1, 100);
        endcase
    endfunction

    // Stimulus and verdict
    initial begin
        int unsigned          f;
        int unsigned          sel;
        logic [ADDR_W-1:0]    addr;
        logic [CFG_DATA_W-1:0] cfg_word;

        i_rst_n              = 1'b0;
        quiet_mode           = 1'b0;
        hold_request         = 1'b0;
        send_idle_pct        = 20;
        stall_pct            = 20;
        cur_base             = 0;
        cur_limit            = 0;
        req_bus.valid        = 1'b0;
        req_bus.action       = ACT_ALLOC;
        req_bus.address      = '0;
        req_bus.frame_number = '0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.index        = REG_BASE_ADDRESS;
        cfg_bus.data         = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Empty region after reset: nothing to allocate, every frame out of range
        issue(ACT_ALLOC, '0, '0);
        issue(ACT_MARK_USED, '0, '0);
        issue(ACT_FREE_ADDR, '0, '0);
        settle();

        // Base near the top of the address space, partial last word
        write_reg(REG_BASE_ADDRESS, 32'hFFFF_F000);
        write_reg(REG_FRAME_COUNT, 32'd37);
        issue(ACT_ALLOC, '0, '0);
        issue(ACT_ALLOC, '0, '0);                 // address wraps to zero
        issue(ACT_MARK_USED, '0, 17'd36);
        issue(ACT_MARK_USED, '0, 17'd37);         // first frame past the limit
        issue(ACT_MARK_USED, '0, 17'd36);         // redundant mark
        issue(ACT_FREE_ADDR, 32'h0000_0ABC, '0);  // offset inside frame ignored
        issue(ACT_FREE_ADDR, 32'hFFFF_E000, '0);  // below base wraps out of range
        issue(ACT_FREE_ADDR, 32'hFFFF_FFFF, '0);
        issue(ACT_ALLOC, '0, '0);
        issue(ACT_MARK_FREE, '0, 17'd36);
        issue(ACT_MARK_FREE, '0, 17'd36);         // redundant free
        issue(ACT_MARK_FREE, '0, 17'h1FFFF);
        settle();

        // Count above capacity is clamped; spare indexes are ignored
        write_reg(REG_BASE_ADDRESS, 32'h0000_0000);
        write_reg(REG_FRAME_COUNT, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_A, $urandom);
        write_reg(REG_SPARE_B, 32'hFFFF_FFFF);
        issue(ACT_MARK_USED, '0, 17'h1FFFF);
        issue(ACT_FREE_ADDR, 32'hFFFF_FFFF, '0);
        issue(ACT_ALLOC, '0, '0);
        issue(ACT_FREE_ADDR, 32'h1FFF_F000, '0);
        issue(ACT_MARK_USED, '0, 17'h1FFFF);
        settle();

        // Shrink the region; bits beyond the new limit stay counted
        write_reg(REG_FRAME_COUNT, 32'd2);
        issue(ACT_ALLOC, '0, '0);
        issue(ACT_ALLOC, '0, '0);
        issue(ACT_MARK_FREE, '0, 17'd2);

        // Random phases, each with its own region and handshake pressure
        for (int phase = 0; phase < PHASES; phase++) begin
            settle();
            case ($urandom_range(0, 3))
                0:       cfg_word = '0;
                1:       cfg_word = '1;
                default: cfg_word = $urandom;
            endcase
            write_reg(REG_BASE_ADDRESS, cfg_word);
            cfg_word = {14'($urandom), 18'(pick_count())};
            write_reg(REG_FRAME_COUNT, cfg_word);
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, $urandom);

            if (phase == PHASES - 1) begin
                quiet_mode    = 1'b1;
                send_idle_pct = 0;
                stall_pct     = 0;
            end else begin
                sel           = $urandom_range(0, 2);
                send_idle_pct = (sel == 0) ? 0 : (sel == 1) ? 10 : 30;
                sel           = $urandom_range(0, 2);
                stall_pct     = (sel == 0) ? 0 : (sel == 1) ? 10 : 30;
            end

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (phase == 2 && n == 10)
                    hold_request = 1'b1;
                f   = pick_frame(cur_limit);
                sel = $urandom_range(0, 99);
                if (sel < 45) begin
                    issue(ACT_ALLOC, $urandom, FNUM_W'($urandom));
                end else if (sel < 65) begin
                    if ($urandom_range(0, 9) == 0)
                        addr = $urandom;
                    else
                        addr = cur_base + (f << FRAME_SHIFT_DEF)
                             + $urandom_range(0, (1 << FRAME_SHIFT_DEF) - 1);
                    issue(ACT_FREE_ADDR, addr, FNUM_W'($urandom));
                end else if (sel < 80) begin
                    issue(ACT_MARK_USED, $urandom, f[FNUM_W-1:0]);
                end else begin
                    issue(ACT_MARK_FREE, $urandom, f[FNUM_W-1:0]);
                end
            end
        end

        // Drain and give the verdict
        settle();
        repeat (50) @(posedge i_clk);
        if (mismatches == 0)
            $display("bitmap_frame_allocator_tb passed");
        else
            $display("bitmap_frame_allocator_tb failed");
        $finish;
    end

endmodule
